// File: rtl/core/mfhd_pkg.sv
// shared types, constants and length rules of the mqtt fixed header deframer
`default_nettype none

package mfhd_pkg;

   localparam int MAX_LENGTH_BYTES = 4;
   localparam int LEN_W            = 28;
   localparam int PKT_SIZE_W       = 29;
   localparam int CSR_INDEX_W      = 2;
   localparam logic [LEN_W-1:0] CONNECT_MAX_LENGTH = 28'd100000;

   localparam logic [CSR_INDEX_W-1:0] CSR_BROKER_CHECKS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IS_BRIDGE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTOCOL_MQTT5  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PACKET_SIZE = 2'd3;

   localparam logic [3:0] PKT_CONNECT    = 4'h1;
   localparam logic [3:0] PKT_PUBACK     = 4'h4;
   localparam logic [3:0] PKT_PUBREC     = 4'h5;
   localparam logic [3:0] PKT_PUBREL     = 4'h6;
   localparam logic [3:0] PKT_PUBCOMP    = 4'h7;
   localparam logic [3:0] PKT_UNSUBACK   = 4'hB;
   localparam logic [3:0] PKT_PINGREQ    = 4'hC;
   localparam logic [3:0] PKT_PINGRESP   = 4'hD;
   localparam logic [3:0] PKT_DISCONNECT = 4'hE;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_PROTOCOL  = 2'd1,
      ST_MALFORMED = 2'd2,
      ST_OVERSIZE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LEN  = 2'd1,
      PH_PAY  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       session_new;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       payload_byte;
      logic             payload_valid;
      logic [LEN_W-1:0] payload_offset;
      logic [7:0]       command_byte;
      logic [LEN_W-1:0] packet_length;
      logic             header_done;
      logic             packet_done;
      logic             disconnect_too_large;
   } rsp_type;

   typedef struct packed {
      logic                  broker_checks;
      logic                  is_bridge;
      logic                  protocol_mqtt5;
      logic [PKT_SIZE_W-1:0] max_packet_size;
   } cfg_type;

   typedef struct packed {
      phase_type        phase;
      logic [7:0]       held_command;
      logic [LEN_W-1:0] length_accum;
      logic [2:0]       length_bytes_seen;
      logic [LEN_W-1:0] bytes_left;
      logic [LEN_W-1:0] payload_position;
   } state_type;

   // per-command remaining length rule, 1 means malformed
   function automatic logic length_rule(input logic [7:0] cmd, input logic [LEN_W-1:0] len,
                                        input logic mqtt5);
      logic bad;
      bad = 1'b0;
      case (cmd[7:4])
         PKT_CONNECT: bad = len > CONNECT_MAX_LENGTH;
         PKT_PUBACK, PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP, PKT_UNSUBACK:
            bad = !mqtt5 && (len != 28'd2);
         PKT_PINGREQ, PKT_PINGRESP: bad = len != '0;
         PKT_DISCONNECT: bad = !mqtt5 && (len != '0);
         default: bad = 1'b0;
      endcase
      return bad;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/mqtt_fixed_header_deframer.sv
// top level of the mqtt fixed header deframer: input stage, parser state, result stage
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_data (data byte, session_new, chunk_end)
//   rsp_      out        rsp_valid / rsp_ready   rsp_data (status, payload, header fields)
//   csr_      in         csr_write_enable        csr_index, csr_write_data
//
// one byte per cycle unless the result stalls; bytes pass input stage, then result stage
// the parser state advances as a byte moves from the input stage to the result stage
// a stalled result holds the pipe while the input stage still takes one more byte
// synchronous reset clears configuration, parser state and both valid flags
`default_nettype none

module mqtt_fixed_header_deframer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire mfhd_pkg::req_type                req_data,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output mfhd_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_write_enable,
   input  wire logic [mfhd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mfhd_pkg::PKT_SIZE_W-1:0]  csr_write_data
);
   import mfhd_pkg::*;

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   rsp_type   res;
   req_type   in_data_ff;
   logic      in_valid_ff;
   rsp_type   rsp_data_ff;
   logic      rsp_valid_ff;
   logic      advance;

   mfhd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mfhd_step u_step (
      .st      (state_ff),
      .cfg     (cfg),
      .item    (in_data_ff),
      .st_next (state_in),
      .res     (res)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_payload_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.payload_valid |-> rsp_data.status == ST_OK)
      else $error("payload transaction with error status");

   a_disc_oversize : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.disconnect_too_large |-> rsp_data.status == ST_OVERSIZE)
      else $error("disconnect request without oversize status");

   a_header_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.header_done |-> rsp_data.status == ST_OK && !rsp_data.payload_valid)
      else $error("header completion with error or payload");

   a_pay_left : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_PAY |-> state_ff.bytes_left != '0)
      else $error("payload phase with no bytes left");

   a_done_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_done |-> rsp_data.header_done || rsp_data.payload_valid)
      else $error("packet end on neither header nor payload byte");

endmodule

`default_nettype wire

// File: rtl/core/mfhd_csr.sv
// configuration registers of the deframer
`default_nettype none

module mfhd_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [mfhd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mfhd_pkg::PKT_SIZE_W-1:0]  csr_write_data,
   output mfhd_pkg::cfg_type                     cfg
);
   import mfhd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BROKER_CHECKS:   cfg_in.broker_checks   = csr_write_data[0];
            CSR_IS_BRIDGE:       cfg_in.is_bridge       = csr_write_data[0];
            CSR_PROTOCOL_MQTT5:  cfg_in.protocol_mqtt5  = csr_write_data[0];
            CSR_MAX_PACKET_SIZE: cfg_in.max_packet_size = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/mfhd_step.sv
// per-byte parse logic: next parser state and result for one byte
`default_nettype none

module mfhd_step (
   input  wire mfhd_pkg::state_type st,
   input  wire mfhd_pkg::cfg_type   cfg,
   input  wire mfhd_pkg::req_type   item,
   output mfhd_pkg::state_type      st_next,
   output mfhd_pkg::rsp_type        res
);
   import mfhd_pkg::*;

   logic [LEN_W-1:0]      group;
   logic [LEN_W-1:0]      accum;
   logic [PKT_SIZE_W-1:0] total;
   logic [LEN_W-1:0]      left;
   logic                  reject_first;

   // seven bit length group placed at its position
   always_comb begin
      case (st.length_bytes_seen[1:0])
         2'd0:    group = {21'd0, item.data_byte[6:0]};
         2'd1:    group = {14'd0, item.data_byte[6:0], 7'd0};
         2'd2:    group = {7'd0, item.data_byte[6:0], 14'd0};
         default: group = {item.data_byte[6:0], 21'd0};
      endcase
   end

   assign accum = st.length_accum + group;
   assign total = {1'b0, accum} + 29'd1;
   assign left  = st.bytes_left - 28'd1;
   assign reject_first = cfg.broker_checks && !cfg.is_bridge && item.session_new
                         && (item.data_byte[7:4] != PKT_CONNECT);

   always_comb begin
      st_next = st;
      res     = '0;
      res.status = ST_OK;
      case (st.phase)
         PH_LEN: begin
            res.command_byte = st.held_command;
            if (st.length_bytes_seen >= 3'(MAX_LENGTH_BYTES)) begin
               res.packet_length = st.length_accum;
               res.status        = ST_MALFORMED;
               st_next           = '0;
            end else begin
               st_next.length_accum      = accum;
               st_next.length_bytes_seen = st.length_bytes_seen + 3'd1;
               res.packet_length         = accum;
               if (!item.data_byte[7]) begin
                  if (cfg.broker_checks
                      && length_rule(st.held_command, accum, cfg.protocol_mqtt5)) begin
                     res.status = ST_MALFORMED;
                     st_next    = '0;
                  end else if (cfg.broker_checks && (cfg.max_packet_size != '0)
                               && (total > cfg.max_packet_size)) begin
                     res.status               = ST_OVERSIZE;
                     res.disconnect_too_large = cfg.protocol_mqtt5;
                     st_next                  = '0;
                  end else begin
                     res.header_done = 1'b1;
                     if (accum == '0) begin
                        res.packet_done = 1'b1;
                        st_next         = '0;
                     end else begin
                        st_next.bytes_left       = accum;
                        st_next.payload_position = '0;
                        st_next.phase            = PH_PAY;
                     end
                  end
               end
            end
         end
         PH_PAY: begin
            res.command_byte   = st.held_command;
            res.packet_length  = st.length_accum;
            res.payload_byte   = item.data_byte;
            res.payload_valid  = 1'b1;
            res.payload_offset = st.payload_position;
            st_next.payload_position = st.payload_position + 28'd1;
            st_next.bytes_left       = left;
            if (left == '0) begin
               res.packet_done = 1'b1;
               st_next         = '0;
            end
         end
         default: begin
            // idle; an unused phase code takes the same path but clears the held command on a rejected first byte
            res.command_byte = item.data_byte;
            st_next          = '0;
            st_next.held_command = st.held_command;
            if (reject_first) begin
               res.status = ST_PROTOCOL;
               if (st.phase != PH_IDLE) begin
                  st_next.held_command = '0;
               end
            end else begin
               st_next.held_command = item.data_byte;
               st_next.phase        = PH_LEN;
            end
         end
      endcase
   end

endmodule

`default_nettype wire
